@@ rtl/core/skdmt_pkg.sv @@
// shared types, codes and defaults for the string key direct mapped table
`default_nettype none
package skdmt_pkg;

   localparam int SLOT_COUNT_DEF = 10;
   localparam int NAME_BYTES_DEF = 256;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OCCUPIED  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         key_byte;
      logic               key_last;
      logic signed [31:0] entry_value;
   } skdmt_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_value;
      logic [3:0]         slot_index;
   } skdmt_rsp_type;

   typedef struct packed {
      logic load;
      logic quot;
      logic rem;
      logic decide;
      logic walk;
      logic finish;
   } skdmt_cmd_type;

   typedef struct packed {
      logic item_last;
      logic need_walk;
      logic walk_done;
   } skdmt_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/skdmt_ctrl.sv @@
// controller state machine sequencing hash, decision and key walk
`default_nettype none
module skdmt_ctrl
   import skdmt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire skdmt_stat_type stat,
   output logic                busy,
   output skdmt_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_QUOT = 3'd1;
   localparam logic [2:0] S_REM  = 3'd2;
   localparam logic [2:0] S_DEC  = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            cmd.quot = 1'b1;
            state_in = S_REM;
         end
         S_REM: begin
            cmd.rem  = 1'b1;
            state_in = stat.item_last ? S_DEC : S_IDLE;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            if (stat.need_walk) begin
               state_in = S_WALK;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/skdmt_dpath.sv @@
// datapath: running hash, key buffer, slot store and byte walk
`default_nettype none
module skdmt_dpath
   import skdmt_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire skdmt_req_type req_item,
   input  wire skdmt_cmd_type cmd,
   output skdmt_stat_type     stat,
   output logic               rsp_valid,
   output skdmt_rsp_type      rsp_item
);

   localparam int KEY_MAX = NAME_BYTES - 1;
   localparam int KW      = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int CW      = $clog2(NAME_BYTES + 1);
   localparam int SW      = $clog2(SLOT_COUNT);
   localparam int AW      = $clog2(SLOT_COUNT + 255);
   localparam int PW      = AW + 8;
   localparam int NAME_DEPTH = SLOT_COUNT * (2 ** KW);

   localparam logic [PW-1:0] RECIP    = PW'((2 ** PW) / SLOT_COUNT);
   localparam logic [PW-1:0] SLOTS_P  = PW'(SLOT_COUNT);
   localparam logic [CW-1:0] CNT_MAX  = CW'(NAME_BYTES);
   localparam logic [CW-1:0] KEY_LIM  = CW'(KEY_MAX);

   logic [SW-1:0]        hash_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 last_ff;
   logic                 type_ff;
   logic signed [31:0]   value_ff;
   logic [PW-1:0]        prod_ff;
   logic [PW-1:0]        quot_ff;
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [CW-1:0]        len_ff [SLOT_COUNT];
   logic signed [31:0]   val_ff [SLOT_COUNT];

   logic [7:0]           key_mem  [KEY_MAX];
   logic [7:0]           name_mem [NAME_DEPTH];

   logic [CW-1:0]        iss_ff;
   logic                 pend_ff;
   logic [KW-1:0]        dat_idx_ff;
   logic                 miss_ff;
   logic [7:0]           kb_rd_ff;
   logic [7:0]           nm_rd_ff;

   logic                 rsp_valid_ff;
   skdmt_rsp_type        rsp_ff;
   skdmt_rsp_type        rsp_in;

   logic [AW-1:0]        sum_w;
   logic [PW-1:0]        prod_w;
   logic [2*PW-1:0]      qprod_w;
   logic [PW-1:0]        qs_w;
   logic [PW-1:0]        rem0_w;
   logic [PW-1:0]        rem1_w;
   logic                 too_long;
   logic                 sel_valid;
   logic                 len_match;
   logic                 need_walk;
   logic                 more;
   logic                 issue;
   logic [SW+3:0]        slot_wide;

   // hash stages
   assign sum_w   = AW'(hash_ff) + AW'(req_item.key_byte);
   assign prod_w  = PW'(sum_w) * PW'(req_item.key_byte);
   assign qprod_w = (2*PW)'(prod_ff) * (2*PW)'(RECIP);
   assign qs_w    = PW'(quot_ff * SLOTS_P);
   assign rem0_w  = prod_ff - qs_w;
   assign rem1_w  = (rem0_w >= SLOTS_P) ? (rem0_w - SLOTS_P) : rem0_w;

   // decision on the hashed slot
   assign too_long  = (cnt_ff == CNT_MAX);
   assign sel_valid = valid_ff[hash_ff];
   assign len_match = (len_ff[hash_ff] == cnt_ff);
   assign need_walk = !too_long &&
                      ((type_ff == REQ_LOOKUP) ? (sel_valid && len_match) : !sel_valid);

   assign more  = (iss_ff < cnt_ff);
   assign issue = cmd.walk && more;

   assign stat.item_last = last_ff;
   assign stat.need_walk = need_walk;
   assign stat.walk_done = !more && !pend_ff;

   assign slot_wide = {4'b0000, hash_ff};

   always_comb begin
      rsp_in.status      = ST_OK;
      rsp_in.found_value = '0;
      rsp_in.slot_index  = slot_wide[3:0];
      priority if (too_long) begin
         rsp_in.status     = ST_TOO_LONG;
         rsp_in.slot_index = '0;
      end else if (type_ff == REQ_LOOKUP) begin
         if (cmd.walk && !miss_ff) begin
            rsp_in.found_value = val_ff[hash_ff];
         end else begin
            rsp_in.status = ST_NOT_FOUND;
         end
      end else if (!cmd.walk) begin
         rsp_in.status = ST_OCCUPIED;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         miss_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.load) begin
            last_ff <= req_item.key_last;
            if (cnt_ff < CNT_MAX) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (cmd.rem) begin
            hash_ff <= rem1_w[SW-1:0];
         end
         if (cmd.decide) begin
            iss_ff  <= '0;
            pend_ff <= 1'b0;
            miss_ff <= 1'b0;
            if (need_walk && (type_ff == REQ_INSERT)) begin
               valid_ff[hash_ff] <= 1'b1;
            end
         end
         if (cmd.walk) begin
            pend_ff <= issue;
            if (issue) begin
               iss_ff <= iss_ff + CW'(1);
            end
            if (pend_ff && (type_ff == REQ_LOOKUP) && (kb_rd_ff != nm_rd_ff)) begin
               miss_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            hash_ff <= '0;
            cnt_ff  <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_item.req_type;
         value_ff <= req_item.entry_value;
         prod_ff  <= prod_w;
      end
      if (cmd.quot) begin
         quot_ff <= qprod_w[2*PW-1:PW];
      end
      if (cmd.decide && need_walk && (type_ff == REQ_INSERT)) begin
         len_ff[hash_ff] <= cnt_ff;
         val_ff[hash_ff] <= value_ff;
      end
      if (issue) begin
         dat_idx_ff <= iss_ff[KW-1:0];
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // key buffer
   always_ff @(posedge clock) begin
      if (cmd.load && (cnt_ff < KEY_LIM)) begin
         key_mem[cnt_ff[KW-1:0]] <= req_item.key_byte;
      end
      if (issue) begin
         kb_rd_ff <= key_mem[iss_ff[KW-1:0]];
      end
   end

   // stored names, one row per slot
   always_ff @(posedge clock) begin
      if (cmd.walk && pend_ff && (type_ff == REQ_INSERT)) begin
         name_mem[{hash_ff, dat_idx_ff}] <= kb_rd_ff;
      end
      if (issue) begin
         nm_rd_ff <= name_mem[{hash_ff, iss_ff[KW-1:0]}];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/string_key_direct_mapped_table_unit.sv @@
// top level of the string key direct mapped table
//
// input: one key byte per item, taken at a clock edge with start high and busy
// low; req_type and entry_value count on the byte marked key_last.
// output: one result per key, on rsp_item for exactly one cycle with rsp_valid
// high; the receiver cannot hold it off and the block never waits on it.
// every byte passes the product, reciprocal quotient and remainder steps of
// the hash, which feeds the next byte through one shared modulo unit.
// a last byte adds a decision step; rsp_valid rises in the cycle after it if
// an insert finds the slot taken, a lookup finds it empty or of another length,
// or the key is too long. otherwise a successful insert or a length-matched
// lookup walks the key one byte per cycle through the key buffer and name store
// read ports before the result.
// reset clears the hash, the byte count and all slot valid flags, so the
// table comes up empty with no clearing pass; stored names, lengths and
// values are only read behind a valid flag.
`default_nettype none
module string_key_direct_mapped_table_unit
   import skdmt_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire skdmt_req_type req_item,
   output logic               rsp_valid,
   output skdmt_rsp_type      rsp_item
);

   skdmt_cmd_type  cmd;
   skdmt_stat_type stat;

   skdmt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   skdmt_dpath #(
      .SLOT_COUNT (SLOT_COUNT),
      .NAME_BYTES (NAME_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

@@ rtl/core/skdmt_checker.sv @@
// port level checks on the table unit and their binding
`default_nettype none
module skdmt_checker
   import skdmt_pkg::*;
(
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          start,
   input wire logic          busy,
   input wire skdmt_req_type req_item,
   input wire logic          rsp_valid,
   input wire skdmt_rsp_type rsp_item
);

   // a result only follows work in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a busy cycle before it");

   // a result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a byte that is not last gives no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_item.key_last) |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result after a byte that is not last");

   // only a found key carries a value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ST_OK)) |-> (rsp_item.found_value == '0))
      else $error("value on a failed request");

   // a rejected long key names slot zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ST_TOO_LONG)) |-> (rsp_item.slot_index == '0))
      else $error("slot on a too long key");

endmodule

bind string_key_direct_mapped_table_unit skdmt_checker u_checker (.*);
`default_nettype wire
